[rtl/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the epoch-to-calendar converter
// Holds the sequencer states, the result record and the step constants
// that feed the shared subtractor.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int SECONDS_W = 38;
    localparam int DAYS_W    = 22;

    localparam logic [SECONDS_W-1:0] MAX_SECONDS   = 38'd253402300799;
    localparam logic [SECONDS_W-1:0] SECS_PER_DAY  = 38'd86400;
    localparam logic [SECONDS_W-1:0] SECS_PER_HOUR = 38'd3600;
    localparam logic [SECONDS_W-1:0] SECS_PER_MIN  = 38'd60;
    localparam logic [SECONDS_W-1:0] DAYS_PER_400Y = 38'd146097;
    localparam logic [SECONDS_W-1:0] DAYS_PER_100Y = 38'd36524;
    localparam logic [SECONDS_W-1:0] DAYS_PER_4Y   = 38'd1461;
    localparam logic [SECONDS_W-1:0] DAYS_PER_1Y   = 38'd365;

    // Days from 1601-01-01 to 1970-01-01.
    localparam logic [SECONDS_W-1:0] DAYS_1601_TO_1970 = 38'd134774;
    localparam logic [13:0]          FIRST_YEAR        = 14'd1601;
    localparam logic [13:0]          YEAR_OFFSET       = 14'd1900;

    localparam logic [4:0] DAY_STEPS  = 5'd22;
    localparam logic [4:0] HOUR_STEPS = 5'd5;
    localparam logic [4:0] MIN_STEPS  = 5'd6;
    localparam logic [4:0] Y400_STEPS = 5'd5;
    localparam logic [4:0] Y100_STEPS = 5'd2;
    localparam logic [4:0] Y4_STEPS   = 5'd5;
    localparam logic [4:0] Y1_STEPS   = 5'd2;

    localparam logic [3:0] LAST_MONTH = 4'd11;
    localparam logic [3:0] FEBRUARY   = 4'd1;
    localparam logic [4:0] LAST_4Y    = 5'd24;
    localparam logic [1:0] LAST_100Y  = 2'd3;
    localparam logic [1:0] LAST_1Y    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAYS,
        ST_HOUR,
        ST_MIN,
        ST_PREP,
        ST_Y400,
        ST_Y100,
        ST_Y4,
        ST_Y1,
        ST_MON,
        ST_DONE
    } esc_state_t;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [12:0] years_since_1900;
        logic [8:0]  day_of_year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
    } esc_result_t;

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            FEBRUARY:                len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [SECONDS_W-1:0] step_operand(
        input esc_state_t st,
        input logic [4:0] k,
        input logic [3:0] mon,
        input logic       leap
    );
        logic [SECONDS_W-1:0] op;
        unique case (st)
            ST_DAYS: op = SECS_PER_DAY << k;
            ST_HOUR: op = SECS_PER_HOUR << k;
            ST_MIN:  op = SECS_PER_MIN << k;
            ST_Y400: op = DAYS_PER_400Y << k;
            ST_Y100: op = DAYS_PER_100Y << k;
            ST_Y4:   op = DAYS_PER_4Y << k;
            ST_Y1:   op = DAYS_PER_1Y << k;
            ST_MON:  op = SECONDS_W'(month_days(mon, leap));
            default: op = '0;
        endcase
        return op;
    endfunction

    function automatic logic [13:0] year_step(input esc_state_t st, input logic [4:0] k);
        logic [13:0] yr;
        unique case (st)
            ST_Y400: yr = 14'd400 << k;
            ST_Y100: yr = 14'd100 << k;
            ST_Y4:   yr = 14'd4 << k;
            ST_Y1:   yr = 14'd1 << k;
            default: yr = '0;
        endcase
        return yr;
    endfunction

    // Since 8 is 1 modulo 7, the octal digits sum to the same residue.
    function automatic logic [2:0] mod7(input logic [23:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = '0;
        for (int i = 0; i < 8; i++)
        begin
            s1 = s1 + 6'(v[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        return (s3 == 4'd7) ? 3'd0 : s3[2:0];
    endfunction

endpackage

[rtl/esc_core.sv]
// ----------------------------------------------------------------------------
// esc_core: sequencer and shared subtractor
// Splits a second count into time of day, then steps off 400, 100, 4 and
// 1 year blocks and months, all through one restoring subtract unit.
// ----------------------------------------------------------------------------
module esc_core
    import esc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SECONDS_W-1:0] seconds,
    output logic                 idle,
    output logic                 res_valid,
    input  logic                 res_take,
    output esc_result_t          res
);

    esc_state_t           state_reg, state_next;
    logic [4:0]           k_reg, k_next;
    logic [SECONDS_W-1:0] acc_reg, acc_next;
    logic [DAYS_W-1:0]    q_reg, q_next;
    logic [DAYS_W-1:0]    days_reg, days_next;
    logic [4:0]           hour_reg, hour_next;
    logic [5:0]           minute_reg, minute_next;
    logic [5:0]           second_reg, second_next;
    logic [2:0]           wday_reg, wday_next;
    logic [13:0]          year_reg, year_next;
    logic [1:0]           n100_reg, n100_next;
    logic [4:0]           n4_reg, n4_next;
    logic                 leap_reg, leap_next;
    logic [8:0]           yday_reg, yday_next;
    logic [3:0]           mon_reg, mon_next;
    logic [4:0]           mday_reg, mday_next;

    logic [SECONDS_W-1:0] operand;
    logic [SECONDS_W:0]   diff;
    logic                 ge;
    logic [DAYS_W-1:0]    q_shift;
    logic [1:0]           n1;

    assign operand = step_operand(state_reg, k_reg, mon_reg, leap_reg);
    assign diff    = {1'b0, acc_reg} - {1'b0, operand};
    assign ge      = !diff[SECONDS_W];
    assign q_shift = {q_reg[DAYS_W-2:0], ge};
    assign n1      = q_shift[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        q_reg      <= q_next;
        days_reg   <= days_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        wday_reg   <= wday_next;
        year_reg   <= year_next;
        n100_reg   <= n100_next;
        n4_reg     <= n4_next;
        leap_reg   <= leap_next;
        yday_reg   <= yday_next;
        mon_reg    <= mon_next;
        mday_reg   <= mday_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        q_next      = q_reg;
        days_next   = days_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        wday_next   = wday_reg;
        year_next   = year_reg;
        n100_next   = n100_reg;
        n4_next     = n4_reg;
        leap_next   = leap_reg;
        yday_next   = yday_reg;
        mon_next    = mon_reg;
        mday_next   = mday_reg;

        if (state_reg inside {ST_DAYS, ST_HOUR, ST_MIN, ST_Y400, ST_Y100, ST_Y4, ST_Y1})
        begin
            q_next = q_shift;
            if (ge)
            begin
                acc_next  = diff[SECONDS_W-1:0];
                year_next = year_reg + year_step(state_reg, k_reg);
            end
            k_next = k_reg - 5'd1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    acc_next   = seconds;
                    k_next     = DAY_STEPS - 5'd1;
                    state_next = ST_DAYS;
                end
            end
            ST_DAYS:
            begin
                if (k_reg == '0)
                begin
                    days_next  = q_shift;
                    k_next     = HOUR_STEPS - 5'd1;
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (k_reg == '0)
                begin
                    hour_next  = q_shift[4:0];
                    k_next     = MIN_STEPS - 5'd1;
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (k_reg == '0)
                begin
                    minute_next = q_shift[5:0];
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                second_next = acc_reg[5:0];
                wday_next   = mod7(24'(days_reg) + 24'd4);
                acc_next    = SECONDS_W'(days_reg) + DAYS_1601_TO_1970;
                year_next   = FIRST_YEAR;
                k_next      = Y400_STEPS - 5'd1;
                state_next  = ST_Y400;
            end
            ST_Y400:
            begin
                if (k_reg == '0)
                begin
                    k_next     = Y100_STEPS - 5'd1;
                    state_next = ST_Y100;
                end
            end
            ST_Y100:
            begin
                if (k_reg == '0)
                begin
                    n100_next  = q_shift[1:0];
                    k_next     = Y4_STEPS - 5'd1;
                    state_next = ST_Y4;
                end
            end
            ST_Y4:
            begin
                if (k_reg == '0)
                begin
                    n4_next    = q_shift[4:0];
                    k_next     = Y1_STEPS - 5'd1;
                    state_next = ST_Y1;
                end
            end
            ST_Y1:
            begin
                if (k_reg == '0)
                begin
                    // The last year of a four-year block is leap, except at a
                    // century end that is not also a 400-year end.
                    leap_next  = (n1 == LAST_1Y) && ((n4_reg != LAST_4Y) || (n100_reg == LAST_100Y));
                    yday_next  = ge ? diff[8:0] : acc_reg[8:0];
                    mon_next   = '0;
                    state_next = ST_MON;
                end
            end
            ST_MON:
            begin
                if ((mon_reg == LAST_MONTH) || !ge)
                begin
                    mday_next  = acc_reg[4:0] + 5'd1;
                    state_next = ST_DONE;
                end
                else
                begin
                    acc_next = diff[SECONDS_W-1:0];
                    mon_next = mon_reg + 4'd1;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign res.second           = second_reg;
    assign res.minute           = minute_reg;
    assign res.hour             = hour_reg;
    assign res.weekday          = wday_reg;
    assign res.years_since_1900 = 13'(year_reg - YEAR_OFFSET);
    assign res.day_of_year      = yday_reg;
    assign res.month            = mon_reg;
    assign res.day_of_month     = mday_reg;

    a_start_begins: assert property (@(posedge clk) disable iff (!rst_n)
        (start && idle) |=> (state_reg == ST_DAYS))
        else $error("start did not begin the day division");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (hour_reg <= 5'd23 && minute_reg <= 6'd59 && second_reg <= 6'd59))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (mon_reg <= LAST_MONTH && mday_reg != 5'd0 && wday_reg <= 3'd6))
        else $error("date fields out of range");

    a_yday_leap: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !leap_reg) |-> (yday_reg <= 9'd364))
        else $error("day 366 in a common year");

endmodule

[rtl/epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: Unix seconds to broken-down UTC date and time
// Top level with the request handshakes and the result register.
// ----------------------------------------------------------------------------
// A request on the input channel (in_valid, in_ready, epoch_seconds) carries
// a count of seconds since 1970-01-01 00:00:00 UTC. Counts above
// 9999-12-31 23:59:59 are clamped to that instant. Each request gives one
// result on the output channel (out_valid, out_ready and the eight fields).
// in_ready is high only while the sequencer is idle; one request is worked
// on at a time. The work runs through one shared subtractor: 22 steps for
// the day count, 11 for hour and minute, 14 for the year blocks and up to
// 12 for the month; the finished result then moves to the output register.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver still stalls when the next result is done, the
// sequencer holds it and takes no new request until the register frees up.
// Reset returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [37:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [12:0] years_since_1900,
    output logic [8:0]  day_of_year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month
);

    logic                 core_idle;
    logic                 core_valid;
    logic                 core_take;
    esc_result_t          core_res;
    logic [SECONDS_W-1:0] seconds_sat;
    logic                 out_valid_reg, out_valid_next;
    esc_result_t          out_res_reg;

    assign seconds_sat = (epoch_seconds > MAX_SECONDS) ? MAX_SECONDS : epoch_seconds;
    assign in_ready    = core_idle;
    assign core_take   = core_valid && (!out_valid_reg || out_ready);

    esc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid),
        .seconds   (seconds_sat),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res_take  (core_take),
        .res       (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_take)
        begin
            out_res_reg <= core_res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign second           = out_res_reg.second;
    assign minute           = out_res_reg.minute;
    assign hour             = out_res_reg.hour;
    assign weekday          = out_res_reg.weekday;
    assign years_since_1900 = out_res_reg.years_since_1900;
    assign day_of_year      = out_res_reg.day_of_year;
    assign month            = out_res_reg.month;
    assign day_of_month     = out_res_reg.day_of_month;

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while the sequencer stayed idle");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_res_reg)))
        else $error("stalled result changed or dropped");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (core_valid && out_valid_reg && !out_ready) |-> !core_take)
        else $error("finished result would overwrite a waiting one");

endmodule
